### design/plsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsa_pkg: shared types and constants
// Beat formats, queue entry format and the fixed luma weights.
// ----------------------------------------------------------------------------
package plsa_pkg;

  // Request kinds on the input channel
  localparam logic REQ_PIXEL       = 1'b0;
  localparam logic REQ_TABLE_WRITE = 1'b1;

  localparam int unsigned SAT_WIDTH = 10;
  localparam logic [SAT_WIDTH-1:0] SAT_RESET = 10'd332;

  // Rec.601-style integer luma weights, sum is 256
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  typedef struct packed {
    logic       req_type;
    logic [7:0] table_index;
    logic [7:0] table_value;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } out_beat_t;

  // Decoded work item: a write hits all three table copies at one address,
  // a pixel reads each copy at its own channel address.
  typedef struct packed {
    logic       is_write;
    logic [7:0] addr_r;
    logic [7:0] addr_g;
    logic [7:0] addr_b;
    logic [7:0] wdata;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_link_t;

endpackage : plsa_pkg
`default_nettype wire

### design/pixel_lut_saturation_adjust_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_lut_saturation_adjust_unit: tone curve LUT with saturation scaling
// Maps RGB888 pixels through a 256-entry tone table, then scales each
// channel's distance from integer luma by a 2.8 gain and clamps to 0..255.
// ----------------------------------------------------------------------------
//
//   channel   signals                         beat
//   -------   -----------------------------   ---------------------------------
//   input     in_valid / in_ready / in_data   pixel or tone table entry write
//   output    out_valid / out_ready / out_data adjusted pixel, one per pixel
//   config    sat_we / sat_wdata              saturation gain (2.8), no wait
//
// Throughput is one input beat per clock while the output is not stalled, set
// by the single-issue back pipeline; table writes use one slot and give no output beat.
// From acceptance to output valid a pixel passes, with an empty queue, through:
// queue, table read, luma, gain multiply, shift/add/clamp output register.
// The table is held in three copies (one read port per channel); it is not
// cleared at reset, so entries must be written before pixels read them.
// rst is synchronous; it empties the queue and pipeline, gain returns to 332.
// An output stall freezes the back pipeline; the queue keeps taking beats
// until it is full, then in_ready drops.
//
module pixel_lut_saturation_adjust_unit
  import plsa_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_beat_t            out_data,
  input  wire                  sat_we,
  input  wire  [SAT_WIDTH-1:0] sat_wdata
);

  // Saturation gain register, 2.8 unsigned
  logic [SAT_WIDTH-1:0] saturation_scale;
  q_link_t              q_head;
  logic                 q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation_scale <= SAT_RESET;
    end else if (sat_we) begin
      saturation_scale <= sat_wdata;
    end
  end

  // Front: accept and decode beats into the work queue
  plsa_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  // Back: table access and the arithmetic pipeline
  plsa_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .saturation_scale (saturation_scale),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data)
  );

  // Back never pops an empty queue
  a_pop_needs_entry : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head.valid)
    else $error("back popped an empty queue");

  // A queued entry the back did not take is still there next cycle
  a_entry_kept : assert property (@(posedge clk) disable iff (rst)
    (q_head.valid && !q_pop) |=> q_head.valid)
    else $error("queued entry lost while back stalled");

  // Reset leaves the output empty
  a_reset_empties_out : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule : pixel_lut_saturation_adjust_unit
`default_nettype wire

### design/plsa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsa_front: input accept, classify and queue
// Decodes each input beat into a work item and holds it in a small queue.
// ----------------------------------------------------------------------------
module plsa_front
  import plsa_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output q_link_t  q_head,
  input  wire      q_pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         fifo [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  q_entry_t         decoded;

  always_comb begin
    decoded.wdata = in_data.table_value;
    if (in_data.req_type == REQ_TABLE_WRITE) begin
      decoded.is_write = 1'b1;
      decoded.addr_r   = in_data.table_index;
      decoded.addr_g   = in_data.table_index;
      decoded.addr_b   = in_data.table_index;
    end else begin
      decoded.is_write = 1'b0;
      decoded.addr_r   = in_data.red_in;
      decoded.addr_g   = in_data.green_in;
      decoded.addr_b   = in_data.blue_in;
    end
  end

  assign in_ready     = (count != CNT_FULL);
  assign push         = in_valid && in_ready;
  assign pop          = q_pop && (count != '0);
  assign q_head.valid = (count != '0);
  assign q_head.entry = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule : plsa_front
`default_nettype wire

### design/plsa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plsa_back: tone table and saturation pipeline
// Table lookup, luma, gain multiply, then shift/add/clamp into the output reg.
// ----------------------------------------------------------------------------
module plsa_back
  import plsa_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  q_link_t              q_head,
  output logic                 q_pop,
  input  wire  [SAT_WIDTH-1:0] saturation_scale,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_beat_t            out_data
);

  // Three copies of the table so each channel has its own read port
  logic [7:0] mem_r [256];
  logic [7:0] mem_g [256];
  logic [7:0] mem_b [256];

  logic        adv;
  logic        s1_valid, s2_valid, s3_valid;
  logic [7:0]  s1_r, s1_g, s1_b;
  logic [7:0]  s2_r, s2_g, s2_b, s2_y;
  logic [7:0]  s3_y;
  logic signed [19:0] s3_pr, s3_pg, s3_pb;
  logic [15:0] luma_sum;
  logic signed [10:0] gain;

  function automatic logic signed [19:0] scale_diff(input logic [7:0] c,
                                                    input logic [7:0] y,
                                                    input logic signed [10:0] g);
    logic signed [8:0] d;
    d = $signed({1'b0, c}) - $signed({1'b0, y});
    return 20'(d * g);
  endfunction

  function automatic logic [7:0] finish(input logic signed [19:0] p,
                                        input logic [7:0] y);
    logic signed [11:0] sh;
    logic signed [12:0] v;
    sh = 12'(p >>> 8);  // arithmetic shift floors
    v  = $signed({5'd0, y}) + 13'(sh);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 13'sd255) begin
      return 8'd255;
    end else begin
      return v[7:0];
    end
  endfunction

  // Whole pipeline moves together; output reg empty or being taken
  assign adv       = !out_valid || out_ready;
  assign q_pop     = adv && q_head.valid;
  assign gain      = $signed({1'b0, saturation_scale});
  assign luma_sum  = {8'd0, s1_r} * {8'd0, LUMA_R}
                   + {8'd0, s1_g} * {8'd0, LUMA_G}
                   + {8'd0, s1_b} * {8'd0, LUMA_B};

  // Table copies: writes and reads both in program order on advance
  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_pop && q_head.entry.is_write) begin
        mem_r[q_head.entry.addr_r] <= q_head.entry.wdata;
        mem_g[q_head.entry.addr_g] <= q_head.entry.wdata;
        mem_b[q_head.entry.addr_b] <= q_head.entry.wdata;
      end
      s1_r <= mem_r[q_head.entry.addr_r];
      s1_g <= mem_g[q_head.entry.addr_g];
      s1_b <= mem_b[q_head.entry.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r  <= s1_r;
      s2_g  <= s1_g;
      s2_b  <= s1_b;
      s2_y  <= luma_sum[15:8];
      s3_y  <= s2_y;
      s3_pr <= scale_diff(s2_r, s2_y, gain);
      s3_pg <= scale_diff(s2_g, s2_y, gain);
      s3_pb <= scale_diff(s2_b, s2_y, gain);
      out_data.red_out   <= finish(s3_pr, s3_y);
      out_data.green_out <= finish(s3_pg, s3_y);
      out_data.blue_out  <= finish(s3_pb, s3_y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_pop && !q_head.entry.is_write;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

endmodule : plsa_back
`default_nettype wire

### tb/tb_pixel_lut_saturation_adjust_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_lut_saturation_adjust_unit: self-checking bench for the tone LUT
// and saturation unit. A queue-fed driver sends table writes and pixels. A
// scoreboard keeps its own tone table and gain and predicts each output pixel.
// The gain is stepped through zero, identity, maximum and random settings.
// ----------------------------------------------------------------------------
module tb_pixel_lut_saturation_adjust_unit;
  import plsa_pkg::*;

  // Bench-side copies of the arithmetic constants (kept independent of the RTL)
  localparam int WEIGHT_RED    = 77;
  localparam int WEIGHT_GREEN  = 150;
  localparam int WEIGHT_BLUE   = 29;
  localparam int GAIN_AT_RESET = 332;
  localparam int CHANNEL_MAX   = 255;

  localparam int RESET_CYCLES   = 11;
  // Four-stage pipe plus a four-deep queue, with margin: long enough for a
  // trailing table write to land before the gain changes.
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 220;
  localparam int NUM_PHASES     = 7;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_beat_t            out_data;
  logic                 sat_we    = 1'b0;
  logic [SAT_WIDTH-1:0] sat_wdata = '0;

  pixel_lut_saturation_adjust_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .sat_we    (sat_we),
    .sat_wdata (sat_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Scoreboard state: our own tone table and gain, updated in beat order
  // --------------------------------------------------------------------------
  logic [7:0] tone_lut [256];
  int         sat_gain = GAIN_AT_RESET;
  out_beat_t  expected_pixels [$];

  // Generator state: which entries have been written so far. Pixels only
  // index written entries, since unwritten entries hold garbage in the RTL.
  in_beat_t   pending_beats [$];
  bit         lut_known [256];
  int         lut_known_list [$];

  int beats_queued = 0;
  int beats_taken  = 0;
  int pixels_taken = 0;
  int writes_taken = 0;
  int pixels_seen  = 0;
  int gains_used   = 0;
  int fail_count   = 0;
  int idle_pct     = 0;   // sender gap odds per beat, percent
  int stall_pct    = 0;   // receiver stall odds per cycle, percent

  // One channel: scale its distance from luma by the 2.8 gain, floor, clamp.
  function automatic logic [7:0] saturate_channel(input int level, input int luma,
                                                  input int gain);
    int v;
    v = luma + (((level - luma) * gain) >>> 8);
    if (v < 0) return 8'd0;
    if (v > CHANNEL_MAX) return 8'd255;
    return v[7:0];
  endfunction

  // Predicted output for a pixel beat, using the current table and gain.
  function automatic out_beat_t adjust_pixel(input in_beat_t b);
    int r, g, bl, luma;
    out_beat_t res;
    r    = int'(tone_lut[b.red_in]);
    g    = int'(tone_lut[b.green_in]);
    bl   = int'(tone_lut[b.blue_in]);
    luma = (WEIGHT_RED * r + WEIGHT_GREEN * g + WEIGHT_BLUE * bl) >> 8;
    res.red_out   = saturate_channel(r, luma, sat_gain);
    res.green_out = saturate_channel(g, luma, sat_gain);
    res.blue_out  = saturate_channel(bl, luma, sat_gain);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders. Ignored fields get random junk.
  // --------------------------------------------------------------------------
  task automatic queue_write(input int idx, input int val);
    in_beat_t b;
    b.req_type    = REQ_TABLE_WRITE;
    b.table_index = idx[7:0];
    b.table_value = val[7:0];
    b.red_in      = 8'($urandom);
    b.green_in    = 8'($urandom);
    b.blue_in     = 8'($urandom);
    if (!lut_known[idx]) begin
      lut_known[idx] = 1'b1;
      lut_known_list.push_back(idx);
    end
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_pixel(input int r, input int g, input int bl);
    in_beat_t b;
    b.req_type    = REQ_PIXEL;
    b.table_index = 8'($urandom);
    b.table_value = 8'($urandom);
    b.red_in      = r[7:0];
    b.green_in    = g[7:0];
    b.blue_in     = bl[7:0];
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  function automatic int pick_entry();
    return lut_known_list[$urandom_range(0, lut_known_list.size() - 1)];
  endfunction

  // Random phase: mostly pixels over written entries, some table rewrites.
  task automatic queue_random_phase(input int count);
    int r, val;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 4))
          0:       val = 0;
          1:       val = CHANNEL_MAX;
          default: val = $urandom_range(0, CHANNEL_MAX);
        endcase
        queue_write($urandom_range(0, 255), val);
      end else if ($urandom_range(0, 99) < 12) begin
        r = pick_entry();   // neutral input: all channels hit one entry
        queue_pixel(r, r, r);
      end else begin
        queue_pixel(pick_entry(), pick_entry(), pick_entry());
      end
    end
  endtask

  // Block until every queued beat is in and every result is out, then let
  // any trailing table write finish in the pipe.
  task automatic wait_idle();
    do @(posedge clk);
    while (beats_taken != beats_queued || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Gain register write; only called with the unit idle.
  task automatic set_gain(input int g);
    sat_we    <= 1'b1;
    sat_wdata <= g[SAT_WIDTH-1:0];
    @(posedge clk);
    sat_we    <= 1'b0;
    sat_gain  = g;
    gains_used++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued beats, with random gap bursts between them
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      // Accepted beat: update the scoreboard in acceptance order
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_TABLE_WRITE) begin
          tone_lut[in_data.table_index] = in_data.table_value;
          writes_taken++;
        end else begin
          expected_pixels.push_back(adjust_pixel(in_data));
          pixels_taken++;
        end
        beats_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0 && idle_pct != 0 &&
                     $urandom_range(0, 99) < idle_pct) begin
          send_gap = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random stall bursts on out_ready, field-by-field compare
  // --------------------------------------------------------------------------
  int        stall_left = 0;
  out_beat_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          $error("unexpected output beat: %0d %0d %0d",
                 out_data.red_out, out_data.green_out, out_data.blue_out);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.red_out !== want.red_out) begin
            $error("red_out: expected %0d, actual %0d", want.red_out, out_data.red_out);
            fail_count++;
          end
          if (out_data.green_out !== want.green_out) begin
            $error("green_out: expected %0d, actual %0d", want.green_out,
                   out_data.green_out);
            fail_count++;
          end
          if (out_data.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, actual %0d", want.blue_out, out_data.blue_out);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too many cycles with no beat moving on either side
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || sat_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
               quiet_cycles, expected_pixels.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int gain_plan [NUM_PHASES];

    gain_plan[0] = 0;                               // gray output
    gain_plan[1] = 256;                             // identity
    gain_plan[2] = 1023;                            // max gain, heavy clamping
    gain_plan[3] = $urandom_range(1, 255);          // desaturate
    gain_plan[4] = $urandom_range(257, 1022);       // boost
    gain_plan[5] = GAIN_AT_RESET;                   // rewrite of the reset value
    gain_plan[6] = $urandom_range(0, 1023);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset gain: extreme table entries and pixels,
    // pure primaries, neutral gray, and entry overwrites.
    idle_pct  = 10;
    stall_pct = 10;
    queue_write(0, 0);
    queue_write(255, 255);
    queue_write(128, 128);
    queue_write(1, 255);
    queue_write(254, 0);
    queue_write(64, 32);
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(128, 128, 128);
    queue_pixel(1, 254, 128);
    queue_pixel(64, 128, 255);
    queue_write(128, 200);          // overwrite, then read right behind it
    queue_pixel(128, 128, 1);
    queue_write(255, 0);
    queue_pixel(255, 0, 1);
    queue_random_phase(PHASE_ITEMS / 4);
    wait_idle();

    // Gain sweep; the sender holds off and the unit drains before each write.
    // Idle odds rotate so some phases run flat out; the last phase has none.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_gain(gain_plan[p]);
      case (p % 3)
        0:       begin idle_pct = 15; stall_pct = 15; end
        1:       begin idle_pct = 0;  stall_pct = 0;  end
        default: begin idle_pct = 40; stall_pct = 35; end
      endcase
      if (p == NUM_PHASES - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      queue_random_phase(PHASE_ITEMS);
      wait_idle();
    end

    $display("Ran %0d pixels and %0d table writes over %0d gain settings",
             pixels_taken, writes_taken, gains_used + 1);
    $display("(reset gain, zero, identity, max and random), %0d results checked",
             pixels_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
